FILE: design/dtc_pkg.sv
// Package for the display timing clamp: payload structs, register map,
// limit constants and small clamp helpers. No dependencies.
package dtc_pkg;

   // Arithmetic width for all intermediate timing values
   localparam int CalcW = 13;

   // Register map: one register, card_class, at byte address 0
   localparam int      CsrAddrW       = 3;
   localparam int      CsrDataW       = 32;
   localparam logic    CsrIdxCardClass = 1'b0;

   // Card class codes
   localparam logic [1:0] Class1600 = 2'd0;
   localparam logic [1:0] Class1920 = 2'd1;
   localparam logic [1:0] Class2048 = 2'd2;
   localparam logic [1:0] ClassReset = Class2048;

   // Horizontal constants
   localparam logic [11:0]      HMask       = 12'hff8;
   localparam logic [CalcW-1:0] HDeMax      = 13'd2048;
   localparam logic [CalcW-1:0] HSsMax      = 13'd4080;
   localparam logic [CalcW-1:0] HSeMax      = 13'd4088;
   localparam logic [CalcW-1:0] HDeMin      = 13'd640;
   localparam logic [CalcW-1:0] HTotMinGap  = 13'd80;
   localparam logic [CalcW-1:0] HTotMaxGap  = 13'h3f8;
   localparam logic [CalcW-1:0] HStep       = 13'd8;
   localparam logic [CalcW-1:0] HSyncMaxLen = 13'hf8;

   // Vertical constants
   localparam logic [15:0]      VDeMax      = 16'h07ff;
   localparam logic [15:0]      VSsMax      = 16'h0ffe;
   localparam logic [15:0]      VSeMax      = 16'h0fff;
   localparam logic [15:0]      VTotMax     = 16'h1001;
   localparam logic [CalcW-1:0] VDeMin      = 13'd480;
   localparam logic [CalcW-1:0] VTotMinGap  = 13'd3;
   localparam logic [CalcW-1:0] VTotMaxGap  = 13'hff;
   localparam logic [CalcW-1:0] VStep       = 13'd1;
   localparam logic [CalcW-1:0] VSyncMaxLen = 13'h0f;

   typedef struct packed {
      logic [15:0] h_display_end;
      logic [15:0] h_sync_on;
      logic [15:0] h_sync_off;
      logic [15:0] h_total;
      logic [15:0] v_display_end;
      logic [15:0] v_sync_on;
      logic [15:0] v_sync_off;
      logic [15:0] v_total;
   } dtc_req_type;

   typedef struct packed {
      logic [11:0] adj_h_display_end;
      logic [11:0] adj_h_sync_on;
      logic [11:0] adj_h_sync_off;
      logic [11:0] adj_h_total;
      logic [10:0] adj_v_display_end;
      logic [11:0] adj_v_sync_on;
      logic [11:0] adj_v_sync_off;
      logic [10:0] adj_v_total;
   } dtc_rsp_type;

   function automatic logic [CalcW-1:0] clamp_hi(input logic [CalcW-1:0] v,
                                                 input logic [CalcW-1:0] hi);
      return (v > hi) ? hi : v;
   endfunction

   function automatic logic [CalcW-1:0] clamp_lo(input logic [CalcW-1:0] v,
                                                 input logic [CalcW-1:0] lo);
      return (v < lo) ? lo : v;
   endfunction

   // Clamp a raw 16-bit field and narrow it to the working width
   function automatic logic [CalcW-1:0] clamp_in(input logic [15:0] v,
                                                 input logic [15:0] hi);
      logic [15:0] r;
      r = (v > hi) ? hi : v;
      return r[CalcW-1:0];
   endfunction

   // Display width limit per card class; unused class code acts as the largest
   function automatic logic [CalcW-1:0] width_limit(input logic [1:0] cls);
      logic [CalcW-1:0] r;
      case (cls)
         Class1600: r = 13'd1600;
         Class1920: r = 13'd1920;
         default:   r = 13'd2048;
      endcase
      return r;
   endfunction

   function automatic logic [CalcW-1:0] height_limit(input logic [1:0] cls);
      logic [CalcW-1:0] r;
      case (cls)
         Class1600: r = 13'd1200;
         Class1920: r = 13'd1440;
         default:   r = 13'd1536;
      endcase
      return r;
   endfunction

endpackage

FILE: design/display_timing_clamp_unit.sv
// Top level of the display timing clamp: input register, clamp logic,
// result register and the card_class register. Depends on dtc_pkg.
//
// Usage:
//  - Request channel (req_valid, req_stall, req_data): one mode line per
//    transfer, taken at a clock edge with req_valid high and req_stall low.
//  - Response channel (rsp_valid, rsp_stall, rsp_data): one corrected mode
//    line for each request, in order.
//  - APB port: card_class at byte address 0 selects the size limit
//    (1600x1200, 1920x1440, 2048x1536). Write it only while idle.
//  - rsp_valid rises after the request transfer, once the mode line has
//    passed into the input register and then through the clamp chain into
//    the result register.
//  - Throughput is one mode line per cycle while rsp_stall is low, set by the
//    single registered pass of the clamp chain between the two registers.
//  - A stalled response holds in the result register; the input register
//    still takes one more request, and req_stall rises only once both
//    registers are full and the response is stalled.
//  - Synchronous reset empties both registers and sets card_class to the
//    2048x1536 class.
module display_timing_clamp_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  dtc_pkg::dtc_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output dtc_pkg::dtc_rsp_type         rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [dtc_pkg::CsrAddrW-1:0] paddr,
   input  logic [dtc_pkg::CsrDataW-1:0] pwdata,
   output logic [dtc_pkg::CsrDataW-1:0] prdata,
   output logic                         pready
);

   logic                  in_valid_ff, in_valid_in;
   dtc_pkg::dtc_req_type  in_data_ff;
   logic                  out_valid_ff, out_valid_in;
   dtc_pkg::dtc_rsp_type  out_data_ff, out_data_in;
   logic [1:0]            card_class_ff, card_class_in;
   logic                  out_take;
   logic                  in_take;
   logic                  csr_write;
   logic                  csr_hit;

   // Pipeline flow control
   assign out_take  = !out_valid_ff || !rsp_stall;
   assign in_take   = !in_valid_ff || out_take;
   assign req_stall = !in_take;

   assign in_valid_in  = in_take ? req_valid : in_valid_ff;
   assign out_valid_in = out_take ? in_valid_ff : out_valid_ff;

   // Register port
   assign pready        = 1'b1;
   assign csr_hit       = (paddr[dtc_pkg::CsrAddrW-1] == dtc_pkg::CsrIdxCardClass);
   assign csr_write     = psel && penable && pwrite && pready && csr_hit;
   assign card_class_in = csr_write ? pwdata[1:0] : card_class_ff;
   assign prdata        = csr_hit ? {{(dtc_pkg::CsrDataW-2){1'b0}}, card_class_ff}
                                  : '0;

   // Clamp chain, in the order the register limits demand
   always_comb begin
      logic [dtc_pkg::CalcW-1:0] hde, hss, hse, ht;
      logic [dtc_pkg::CalcW-1:0] vde, vss, vse, vt;

      // horizontal: mask to character clocks, then register limits
      hde = {1'b0, in_data_ff.h_display_end[11:0] & dtc_pkg::HMask};
      hss = {1'b0, in_data_ff.h_sync_on[11:0] & dtc_pkg::HMask};
      hse = {1'b0, in_data_ff.h_sync_off[11:0] & dtc_pkg::HMask};
      ht  = {1'b0, in_data_ff.h_total[11:0] & dtc_pkg::HMask};
      hde = dtc_pkg::clamp_hi(hde, dtc_pkg::HDeMax);
      hss = dtc_pkg::clamp_hi(hss, dtc_pkg::HSsMax);
      hse = dtc_pkg::clamp_hi(hse, dtc_pkg::HSeMax);
      hde = dtc_pkg::clamp_lo(hde, dtc_pkg::HDeMin);
      hde = dtc_pkg::clamp_hi(hde, dtc_pkg::width_limit(card_class_ff));
      ht  = dtc_pkg::clamp_lo(ht, hde + dtc_pkg::HTotMinGap);
      ht  = dtc_pkg::clamp_hi(ht, hde + dtc_pkg::HTotMaxGap);
      hse = dtc_pkg::clamp_hi(hse, ht - dtc_pkg::HStep);
      hss = dtc_pkg::clamp_lo(hss, hde + dtc_pkg::HStep);
      hse = dtc_pkg::clamp_hi(hse, hss + dtc_pkg::HSyncMaxLen);

      // vertical
      vde = dtc_pkg::clamp_in(in_data_ff.v_display_end, dtc_pkg::VDeMax);
      vss = dtc_pkg::clamp_in(in_data_ff.v_sync_on, dtc_pkg::VSsMax);
      vse = dtc_pkg::clamp_in(in_data_ff.v_sync_off, dtc_pkg::VSeMax);
      vt  = dtc_pkg::clamp_in(in_data_ff.v_total, dtc_pkg::VTotMax);
      vde = dtc_pkg::clamp_lo(vde, dtc_pkg::VDeMin);
      vde = dtc_pkg::clamp_hi(vde, dtc_pkg::height_limit(card_class_ff));
      vt  = dtc_pkg::clamp_lo(vt, vde + dtc_pkg::VTotMinGap);
      vt  = dtc_pkg::clamp_hi(vt, vde + dtc_pkg::VTotMaxGap);
      vse = dtc_pkg::clamp_hi(vse, vt - dtc_pkg::VStep);
      vss = dtc_pkg::clamp_lo(vss, vde + dtc_pkg::VStep);
      vse = dtc_pkg::clamp_hi(vse, vss + dtc_pkg::VSyncMaxLen);

      out_data_in.adj_h_display_end = hde[11:0];
      out_data_in.adj_h_sync_on     = hss[11:0];
      out_data_in.adj_h_sync_off    = hse[11:0];
      out_data_in.adj_h_total       = ht[11:0];
      out_data_in.adj_v_display_end = vde[10:0];
      out_data_in.adj_v_sync_on     = vss[11:0];
      out_data_in.adj_v_sync_off    = vse[11:0];
      out_data_in.adj_v_total       = vt[10:0];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         card_class_ff <= dtc_pkg::ClassReset;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         card_class_ff <= card_class_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_data_ff <= req_data;
      end
      if (out_take) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_transfer_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> in_valid_ff)
      else $error("accepted request lost from input register");

   a_h_display_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.adj_h_display_end[2:0] == 3'd0 &&
                     rsp_data.adj_h_display_end >= 12'd640))
      else $error("horizontal display end out of range");

   a_h_sync_after_display: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.adj_h_sync_on} >=
                     {1'b0, rsp_data.adj_h_display_end} + 13'd8))
      else $error("horizontal sync starts inside display area");

   a_v_total_room: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.adj_v_total} >=
                     {1'b0, rsp_data.adj_v_display_end} + 12'd3))
      else $error("vertical total leaves no room for sync");

endmodule

FILE: bench/tb.sv
// Testbench for display_timing_clamp_unit: drives mode lines over the request
// channel, predicts each corrected mode line and checks it against the response
// channel, under several card_class settings. Depends on dtc_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

   // Register addresses and the card class code the package leaves unnamed
   localparam logic [dtc_pkg::CsrAddrW-1:0] AddrCardClass =
      {dtc_pkg::CsrIdxCardClass, 2'b00};
   localparam logic [dtc_pkg::CsrAddrW-1:0] AddrSpare     =
      {~dtc_pkg::CsrIdxCardClass, 2'b00};
   localparam logic [1:0]          ClassUnused   = 2'd3;
   localparam int                  HangLimit     = 4000;
   localparam int                  RandomPerPhase = 190;

   // Scoreboard: expected corrected mode lines in request order
   class mode_scoreboard;
      dtc_pkg::dtc_rsp_type corrected_q[$];
      int          errors;

      function int lim_hi(int v, int hi);
         return (v > hi) ? hi : v;
      endfunction

      function int lim_lo(int v, int lo);
         return (v < lo) ? lo : v;
      endfunction

      // Corrected mode line for one request under the given card class
      function dtc_pkg::dtc_rsp_type clamp_mode(dtc_pkg::dtc_req_type m, logic [1:0] cls);
         int hde, hss, hse, ht, vde, vss, vse, vt, wmax, hmax;
         dtc_pkg::dtc_rsp_type r;
         hde = int'(m.h_display_end & 16'h0ff8);
         hss = int'(m.h_sync_on & 16'h0ff8);
         hse = int'(m.h_sync_off & 16'h0ff8);
         ht  = int'(m.h_total & 16'h0ff8);
         vde = int'(m.v_display_end);
         vss = int'(m.v_sync_on);
         vse = int'(m.v_sync_off);
         vt  = int'(m.v_total);
         case (cls)
            dtc_pkg::Class1600: begin wmax = 1600; hmax = 1200; end
            dtc_pkg::Class1920: begin wmax = 1920; hmax = 1440; end
            default:   begin wmax = 2048; hmax = 1536; end
         endcase
         // horizontal chain
         hde = lim_hi(hde, 2048);
         hss = lim_hi(hss, 4080);
         hse = lim_hi(hse, 4088);
         ht  = lim_hi(ht, 4128);
         hde = lim_hi(lim_lo(hde, 640), wmax);
         ht  = lim_lo(ht, hde + 80);
         ht  = lim_hi(ht, hde + 'h3f8);
         hse = lim_hi(hse, ht - 8);
         hss = lim_lo(hss, hde + 8);
         hse = lim_hi(hse, hss + 'hf8);
         // vertical chain
         vde = lim_hi(vde, 'h7ff);
         vss = lim_hi(vss, 'hffe);
         vse = lim_hi(vse, 'hfff);
         vt  = lim_hi(vt, 'h1001);
         vde = lim_hi(lim_lo(vde, 480), hmax);
         vt  = lim_lo(vt, vde + 3);
         vt  = lim_hi(vt, vde + 'hff);
         vse = lim_hi(vse, vt - 1);
         vss = lim_lo(vss, vde + 1);
         vse = lim_hi(vse, vss + 'h0f);
         r.adj_h_display_end = 12'(hde);
         r.adj_h_sync_on     = 12'(hss);
         r.adj_h_sync_off    = 12'(hse);
         r.adj_h_total       = 12'(ht);
         r.adj_v_display_end = 11'(vde);
         r.adj_v_sync_on     = 12'(vss);
         r.adj_v_sync_off    = 12'(vse);
         r.adj_v_total       = 11'(vt);
         return r;
      endfunction

      function void log_error(string msg);
         if (errors < 10) $display("MISMATCH %s", msg);
         errors++;
      endfunction

      function void note_request(dtc_pkg::dtc_req_type m, logic [1:0] cls);
         corrected_q.push_back(clamp_mode(m, cls));
      endfunction

      function void cmp_field(string name, int exp_v, int got_v);
         if (exp_v != got_v)
            log_error($sformatf("%s: expected %0d, got %0d", name, exp_v, got_v));
      endfunction

      function void check_result(dtc_pkg::dtc_rsp_type got);
         dtc_pkg::dtc_rsp_type exp_r;
         if (corrected_q.size() == 0) begin
            log_error($sformatf("unexpected response %h", got));
            return;
         end
         exp_r = corrected_q.pop_front();
         cmp_field("adj_h_display_end", exp_r.adj_h_display_end, got.adj_h_display_end);
         cmp_field("adj_h_sync_on", exp_r.adj_h_sync_on, got.adj_h_sync_on);
         cmp_field("adj_h_sync_off", exp_r.adj_h_sync_off, got.adj_h_sync_off);
         cmp_field("adj_h_total", exp_r.adj_h_total, got.adj_h_total);
         cmp_field("adj_v_display_end", exp_r.adj_v_display_end, got.adj_v_display_end);
         cmp_field("adj_v_sync_on", exp_r.adj_v_sync_on, got.adj_v_sync_on);
         cmp_field("adj_v_sync_off", exp_r.adj_v_sync_off, got.adj_v_sync_off);
         cmp_field("adj_v_total", exp_r.adj_v_total, got.adj_v_total);
      endfunction

      function int outstanding();
         return corrected_q.size();
      endfunction
   endclass

   logic                         clock   = 1'b0;
   logic                         reset   = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   dtc_pkg::dtc_req_type         req_data = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   dtc_pkg::dtc_rsp_type         rsp_data;
   logic                         psel    = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite  = 1'b0;
   logic [dtc_pkg::CsrAddrW-1:0] paddr   = '0;
   logic [dtc_pkg::CsrDataW-1:0] pwdata  = '0;
   logic [dtc_pkg::CsrDataW-1:0] prdata;
   logic                         pready;

   mode_scoreboard sb = new();
   logic [1:0]     cur_class = dtc_pkg::ClassReset;
   int             idle_style = 1;   // 0: no idling, 1: random gaps and stalls
   int             stall_left = 0;
   int             quiet_cycles = 0;

   display_timing_clamp_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #2 clock = ~clock;

   // Gap length: mostly none or short, now and then long
   function int pick_gap();
      int r;
      if (idle_style == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(10, 40);
   endfunction

   // Response side stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left <= pick_gap();
         rsp_stall <= 1'b0;
      end
   end

   // Transfer monitor: predicts on request transfers, checks response transfers
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_request(req_data, cur_class);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // Watchdog on cycles with no transfer on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HangLimit) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function dtc_pkg::dtc_req_type mode_line(int hde, int hss, int hse, int ht,
                                            int vde, int vss, int vse, int vt);
      dtc_pkg::dtc_req_type m;
      m.h_display_end = 16'(hde);
      m.h_sync_on     = 16'(hss);
      m.h_sync_off    = 16'(hse);
      m.h_total       = 16'(ht);
      m.v_display_end = 16'(vde);
      m.v_sync_on     = 16'(vss);
      m.v_sync_off    = 16'(vse);
      m.v_total       = 16'(vt);
      return m;
   endfunction

   // Values around the clamp thresholds, with a little jitter
   function int boundary_value();
      int v;
      case ($urandom_range(0, 15))
         0:  v = 0;
         1:  v = 8;
         2:  v = 480;
         3:  v = 640;
         4:  v = 1200;
         5:  v = 1440;
         6:  v = 1536;
         7:  v = 1600;
         8:  v = 1920;
         9:  v = 2048;
         10: v = 'h7ff;
         11: v = 'hff0;
         12: v = 'hffe;
         13: v = 'h1001;
         14: v = 4128;
         default: v = 'hffff;
      endcase
      return v + $urandom_range(0, 4) - 2;
   endfunction

   // Random mode line: mostly plausible timings, some boundaries, some noise
   function dtc_pkg::dtc_req_type random_mode();
      int sel, hde, hss, hse, ht, vde, vss, vse, vt;
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
         hde = $urandom_range(560, 2120);
         hss = ($urandom_range(0, 7) == 0) ? hde - $urandom_range(0, 64)
                                           : hde + $urandom_range(0, 48);
         hse = hss + $urandom_range(0, 320);
         ht  = ($urandom_range(0, 7) == 0) ? hde + $urandom_range(0, 100)
                                           : hse + $urandom_range(0, 400);
         vde = $urandom_range(460, 1560);
         vss = ($urandom_range(0, 7) == 0) ? vde - $urandom_range(0, 8)
                                           : vde + $urandom_range(0, 8);
         vse = vss + $urandom_range(0, 24);
         vt  = ($urandom_range(0, 7) == 0) ? vde + $urandom_range(0, 8)
                                           : vse + $urandom_range(0, 300);
         return mode_line(hde, hss, hse, ht, vde, vss, vse, vt);
      end
      if (sel < 8)
         return mode_line(boundary_value(), boundary_value(), boundary_value(),
                          boundary_value(), boundary_value(), boundary_value(),
                          boundary_value(), boundary_value());
      return dtc_pkg::dtc_req_type'({$urandom, $urandom, $urandom, $urandom});
   endfunction

   // One request transfer, then an optional gap; the last one of a phase drops valid
   task send_mode(input dtc_pkg::dtc_req_type m, input bit last);
      int gap;
      req_valid <= 1'b1;
      req_data  <= m;
      do @(posedge clock); while (req_stall);
      gap = pick_gap();
      if (last || gap > 0) begin
         req_valid <= 1'b0;
         req_data  <= dtc_pkg::dtc_req_type'({$urandom, $urandom, $urandom, $urandom});
         repeat (gap) @(posedge clock);
      end
   endtask

   // Setup and access phase, then idle with psel low before the next access
   task csr_access(input logic wr, input logic [dtc_pkg::CsrAddrW-1:0] addr,
                   input logic [dtc_pkg::CsrDataW-1:0] data,
                   output logic [dtc_pkg::CsrDataW-1:0] rd);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task csr_write_class(input logic [dtc_pkg::CsrAddrW-1:0] addr, input logic [1:0] cls);
      logic [dtc_pkg::CsrDataW-1:0] rd;
      csr_access(1'b1, addr, {30'($urandom), cls}, rd);
      if (addr == AddrCardClass) cur_class = cls;
   endtask

   task csr_check_class();
      logic [dtc_pkg::CsrDataW-1:0] rd;
      csr_access(1'b0, AddrCardClass, '0, rd);
      if (rd !== {{(dtc_pkg::CsrDataW-2){1'b0}}, cur_class})
         sb.log_error($sformatf("card_class read: expected %0d, got %0d", cur_class, rd));
   endtask

   // Wait for every corrected mode line to come back, then a short pause
   task drain();
      @(posedge clock);
      while (sb.outstanding() > 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task run_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) idle_style = ($urandom_range(0, 3) == 0) ? 0 : 1;
         send_mode(random_mode(), i == count - 1);
      end
   endtask

   // Extremes, sync inside display, short and long totals, long pulses
   task run_directed();
      send_mode(mode_line(0, 0, 0, 0, 0, 0, 0, 0), 0);
      send_mode(mode_line('hffff, 'hffff, 'hffff, 'hffff, 'hffff, 'hffff, 'hffff, 'hffff), 0);
      send_mode(mode_line(640, 656, 752, 800, 480, 490, 492, 525), 0);
      send_mode(mode_line(1024, 1048, 1184, 1344, 768, 771, 777, 806), 0);
      send_mode(mode_line(1920, 2048, 2256, 2600, 1440, 1441, 1444, 1500), 0);
      send_mode(mode_line(2048, 2096, 2304, 2720, 1536, 1537, 1540, 1570), 0);
      send_mode(mode_line(2049, 2055, 2063, 2071, 'h7ff, 'h800, 'h801, 'h802), 0);
      send_mode(mode_line('h1000, 'h1008, 'h1010, 'h1018, 'h800, 'hffe, 'hfff, 'h1001), 0);
      send_mode(mode_line(1280, 1000, 1100, 1700, 1024, 900, 950, 1100), 0);
      send_mode(mode_line(800, 808, 'hc00, 'hff8, 600, 601, 700, 900), 0);
      send_mode(mode_line(1024, 1032, 1040, 1024, 768, 769, 770, 768), 0);
      send_mode(mode_line(1024, 1032, 1500, 4095, 768, 769, 1000, 'h1000), 0);
      send_mode(mode_line(640, 700, 900, 760, 480, 490, 520, 500), 0);
      send_mode(mode_line('h0287, 'h02a5, 'h02ff, 'h0337, 481, 482, 483, 484), 0);
      send_mode(mode_line(1600, 1608, 1856, 2624, 1200, 1201, 1216, 1455), 0);
      send_mode(mode_line(1608, 1616, 1624, 1632, 1201, 1202, 1203, 1204), 0);
      send_mode(mode_line(639, 647, 655, 663, 479, 480, 481, 482), 0);
      send_mode(mode_line('haaaa, 'haaaa, 'haaaa, 'haaaa, 'haaaa, 'haaaa, 'haaaa, 'haaaa), 0);
      send_mode(mode_line('h5555, 'h5555, 'h5555, 'h5555, 'h5555, 'h5555, 'h5555, 'h5555), 0);
      send_mode(mode_line(2048, 'hff0, 'hff8, 'hff8, 1536, 'hffe, 'hfff, 'h1001), 1);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check_class();

      // reset class, directed mode lines first
      run_directed();
      drain();
      run_random(RandomPerPhase);
      drain();

      csr_write_class(AddrCardClass, dtc_pkg::Class1600);
      csr_check_class();
      run_random(RandomPerPhase);
      drain();

      csr_write_class(AddrCardClass, dtc_pkg::Class1920);
      csr_check_class();
      run_random(RandomPerPhase);
      drain();

      // unused class code behaves as the largest; spare address is ignored
      csr_write_class(AddrCardClass, ClassUnused);
      csr_check_class();
      csr_write_class(AddrSpare, 2'($urandom));
      csr_check_class();
      run_random(RandomPerPhase);
      drain();

      csr_write_class(AddrCardClass, dtc_pkg::Class2048);
      csr_check_class();
      run_random(RandomPerPhase);
      drain();

      if (sb.outstanding() > 0)
         sb.log_error($sformatf("%0d mode lines never returned", sb.outstanding()));
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
